// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the greedy box suppression block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int SCORE_W    = 16;
  localparam int THR_W      = 17;
  localparam int KEPT_W     = 6;
  localparam int FRAC_W     = 16;
  localparam int AREA_W     = 2 * COORD_BITS;
  localparam int UNI_W      = AREA_W + 1;
  localparam int PROD_W     = THR_W + UNI_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [THR_W-1:0]  THR_RESET     = 17'd32768;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_height;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_left;
  } box_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic [SCORE_W-1:0]    score;
    logic                  last_box;
  } in_item_t;

  typedef struct packed {
    logic [KEPT_W-1:0] kept_index;
    logic              last_kept;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RK_LD,
    ST_RK_LAT,
    ST_RK_SWEEP,
    ST_RK_WR,
    ST_SP_RD_I,
    ST_SP_IDX,
    ST_SP_BOXA,
    ST_SP_RD_J,
    ST_SP_NX,
    ST_SP_BOXB,
    ST_SP_IOU,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbn_iou.sv =====
// ----------------------------------------------------------------------------
// gbn_iou
// Overlap test of two boxes on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_iou
  import gbn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire box_t        box_a,
  input  wire box_t        box_b,
  input  wire logic [THR_W-1:0] thr,
  output iou_status_t      status
);

  logic [COORD_BITS-1:0] iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic [AREA_W-1:0]     inter_r, area_r;
  logic [UNI_W-1:0]      uni_r;
  logic [PROD_W-1:0]     prod_r;
  logic [2:0]            step_r;
  logic                  run_r;
  logic [THR_W-1:0]      opa;
  logic [UNI_W-1:0]      opb;
  logic [COORD_BITS:0]   ar, br, ab, bb, x2, y2;
  logic [COORD_BITS-1:0] x1, y1;
  logic [COORD_BITS:0]   iw, ih;
  logic [PROD_W-1:0]     lhs;

  always_comb begin
    x1 = (box_a.box_left > box_b.box_left) ? box_a.box_left : box_b.box_left;
    y1 = (box_a.box_top > box_b.box_top) ? box_a.box_top : box_b.box_top;
    ar = {1'b0, box_a.box_left} + {1'b0, box_a.box_width};
    br = {1'b0, box_b.box_left} + {1'b0, box_b.box_width};
    ab = {1'b0, box_a.box_top} + {1'b0, box_a.box_height};
    bb = {1'b0, box_b.box_top} + {1'b0, box_b.box_height};
    x2 = (ar < br) ? ar : br;
    y2 = (ab < bb) ? ab : bb;
    iw = (x2 > {1'b0, x1}) ? x2 - {1'b0, x1} : '0;
    ih = (y2 > {1'b0, y1}) ? y2 - {1'b0, y1} : '0;
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (step_r)
      3'd0: begin
        opa = THR_W'(iw_r);
        opb = UNI_W'(ih_r);
      end
      3'd1: begin
        opa = THR_W'(aw_r);
        opb = UNI_W'(ah_r);
      end
      3'd2: begin
        opa = THR_W'(bw_r);
        opb = UNI_W'(bh_r);
      end
      3'd4: begin
        opa = thr;
        opb = uni_r;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign lhs = PROD_W'({inter_r, {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      step_r      <= '0;
      status.done <= 1'b0;
      status.hit  <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          run_r       <= 1'b0;
          status.done <= 1'b1;
          status.hit  <= lhs > prod_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      iw_r <= iw[COORD_BITS-1:0];
      ih_r <= ih[COORD_BITS-1:0];
      aw_r <= box_a.box_width;
      ah_r <= box_a.box_height;
      bw_r <= box_b.box_width;
      bh_r <= box_b.box_height;
    end
    prod_r <= opa * opb;
    case (step_r)
      3'd1:    inter_r <= prod_r[AREA_W-1:0];
      3'd2:    area_r  <= prod_r[AREA_W-1:0];
      3'd3:    uni_r   <= {1'b0, area_r} + {1'b0, prod_r[AREA_W-1:0]} - {1'b0, inter_r};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/greedy_box_nms_top.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms_top
// Greedy non-maximum suppression of up to 64 boxes by intersection over union.
// ----------------------------------------------------------------------------
// Boxes are loaded as items on the input channel: an item is taken when start
// is high and busy is low. For a box without last_box busy stays low. The
// item carrying last_box closes the set; busy then rises while the boxes are
// ranked and suppressed. Ranking is done by one score comparator sweeping the
// score memory, and suppression tests box pairs on the shared overlap
// multiplier. Kept indices leave as one-cycle strobes on out_valid in keep
// order, the last one carrying last_kept; it appears in the first cycle with
// busy low again. The receiver cannot stall the results. The threshold
// register sits at address 0 of the APB port; the user must see that it is
// written only while the block is idle, as the block itself does not enforce
// this. Reset returns the threshold to one half and empties the set; the box
// memories need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_box_nms_top
  import gbn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  state_t            state_r, state_nxt;
  logic [THR_W-1:0]  thr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  c_r, c_nxt;
  logic [IDX_W-1:0]  cj_r, cj_nxt;
  logic              cv_r, cv_nxt;
  logic [SCORE_W-1:0] si_r, si_nxt;
  logic [IDX_W-1:0]  nx_r, nx_nxt;
  logic [IDX_W-1:0]  pend_r, pend_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [MAX_BOXES-1:0] supp_r, supp_nxt;
  box_t              box_a_r, box_a_nxt;
  logic              out_valid_nxt;
  out_item_t         out_item_nxt;

  logic              accept;
  logic              load_we;
  logic [IDX_W-1:0]  score_raddr, box_raddr, rank_raddr;
  logic [SCORE_W-1:0] score_rdata;
  logic [IDX_W-1:0]  rank_rdata;
  box_t              box_rdata;
  box_t              box_wdata;
  logic              rank_we;
  logic              iou_start;
  iou_status_t       iou_status;
  logic              last_j, last_i;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign load_we = accept && (count_r < CNT_W'(MAX_BOXES));
  assign pready  = 1'b1;
  assign prdata  = (paddr == REG_THRESHOLD) ? DATA_W'(thr_r) : '0;

  assign box_wdata.box_left   = in_item.box_left;
  assign box_wdata.box_top    = in_item.box_top;
  assign box_wdata.box_width  = in_item.box_width;
  assign box_wdata.box_height = in_item.box_height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_THRESHOLD)) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  gbn_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_item.score),
    .raddr (score_raddr),
    .rdata (score_rdata)
  );

  gbn_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (box_wdata),
    .raddr (box_raddr),
    .rdata (box_rdata)
  );

  gbn_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (c_r),
    .wdata (i_r[IDX_W-1:0]),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  gbn_iou u_iou (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (iou_start),
    .box_a  (box_a_r),
    .box_b  (box_rdata),
    .thr    (thr_r),
    .status (iou_status)
  );

  assign last_j = (j_r + CNT_W'(1)) == n_r;
  assign last_i = (i_r + CNT_W'(1)) == n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      cv_r       <= 1'b0;
      pend_vld_r <= 1'b0;
      out_valid  <= 1'b0;
      supp_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      cv_r       <= cv_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_valid  <= out_valid_nxt;
      supp_r     <= supp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    c_r      <= c_nxt;
    cj_r     <= cj_nxt;
    si_r     <= si_nxt;
    nx_r     <= nx_nxt;
    pend_r   <= pend_nxt;
    box_a_r  <= box_a_nxt;
    out_item <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    cj_nxt        = cj_r;
    cv_nxt        = 1'b0;
    si_nxt        = si_r;
    nx_nxt        = nx_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    supp_nxt      = supp_r;
    box_a_nxt     = box_a_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item;
    score_raddr   = count_r[IDX_W-1:0];
    rank_raddr    = i_r[IDX_W-1:0];
    box_raddr     = rank_rdata;
    rank_we       = 1'b0;
    iou_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = count_r + CNT_W'(load_we);
          if (in_item.last_box) begin
            n_nxt        = count_r + CNT_W'(load_we);
            count_nxt    = '0;
            i_nxt        = '0;
            c_nxt        = '0;
            supp_nxt     = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_RK_LD;
          end
        end
      end
      ST_RK_LD: begin
        score_raddr = i_r[IDX_W-1:0];
        state_nxt   = ST_RK_LAT;
      end
      ST_RK_LAT: begin
        si_nxt    = score_rdata;
        j_nxt     = '0;
        state_nxt = ST_RK_SWEEP;
      end
      ST_RK_SWEEP: begin
        score_raddr = j_r[IDX_W-1:0];
        if (j_r < n_r) begin
          j_nxt  = j_r + CNT_W'(1);
          cv_nxt = 1'b1;
          cj_nxt = j_r[IDX_W-1:0];
        end
        if (cv_r && ((score_rdata > si_r) ||
                     ((score_rdata == si_r) && (cj_r < i_r[IDX_W-1:0])))) begin
          c_nxt = c_r + IDX_W'(1);
        end
        if ((j_r == n_r) && !cv_r) begin
          state_nxt = ST_RK_WR;
        end
      end
      ST_RK_WR: begin
        rank_we = 1'b1;
        c_nxt   = '0;
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = ST_SP_RD_I;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = ST_RK_LD;
        end
      end
      ST_SP_RD_I: begin
        rank_raddr = i_r[IDX_W-1:0];
        state_nxt  = ST_SP_IDX;
      end
      ST_SP_IDX: begin
        box_raddr = rank_rdata;
        if (supp_r[rank_rdata]) begin
          if (last_i) begin
            state_nxt = ST_FLUSH;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = ST_SP_RD_I;
          end
        end else begin
          if (pend_vld_r) begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.kept_index = KEPT_W'(pend_r);
            out_item_nxt.last_kept  = 1'b0;
          end
          pend_nxt     = rank_rdata;
          pend_vld_nxt = 1'b1;
          state_nxt    = ST_SP_BOXA;
        end
      end
      ST_SP_BOXA: begin
        box_a_nxt = box_rdata;
        j_nxt     = i_r + CNT_W'(1);
        if (last_i) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_SP_RD_J;
        end
      end
      ST_SP_RD_J: begin
        rank_raddr = j_r[IDX_W-1:0];
        state_nxt  = ST_SP_NX;
      end
      ST_SP_NX: begin
        box_raddr = rank_rdata;
        nx_nxt    = rank_rdata;
        if (supp_r[rank_rdata]) begin
          if (!last_j) begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = ST_SP_RD_J;
          end else if (last_i) begin
            state_nxt = ST_FLUSH;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = ST_SP_RD_I;
          end
        end else begin
          state_nxt = ST_SP_BOXB;
        end
      end
      ST_SP_BOXB: begin
        iou_start = 1'b1;
        state_nxt = ST_SP_IOU;
      end
      ST_SP_IOU: begin
        if (iou_status.done) begin
          if (iou_status.hit) begin
            supp_nxt[nx_r] = 1'b1;
          end
          if (!last_j) begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = ST_SP_RD_J;
          end else if (last_i) begin
            state_nxt = ST_FLUSH;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = ST_SP_RD_I;
          end
        end
      end
      ST_FLUSH: begin
        out_valid_nxt           = pend_vld_r;
        out_item_nxt.kept_index = KEPT_W'(pend_r);
        out_item_nxt.last_kept  = 1'b1;
        pend_vld_nxt            = 1'b0;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The final kept index leaves only once the block is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_kept) |-> !busy)
    else $error("last kept item while busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_kept) |-> busy)
    else $error("intermediate kept item while idle");

  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.last_box) |=> busy)
    else $error("closing item did not start processing");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_item.last_box) |=> !busy && !out_valid)
    else $error("loading item disturbed the idle state");

endmodule

`default_nettype wire
